// ----- rtl/utfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 codepoint decoder.
package utfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned OutDataW = 24;

  localparam logic [CpW-1:0]    Replacement = 21'h00FFFD;
  localparam logic [CountW-1:0] MaxResults  = 3'd4;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  // What one input beat produces: count beats, all replacements but the last,
  // which carries tail.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CpW-1:0]    tail;
    logic              eot;
  } emit_t;

  function automatic lead_e classify_lead(input logic [ByteW-1:0] b);
    lead_e kind;
    priority if (b[7] == 1'b0)         kind = LEAD_ASCII;
    else if (b[7:5] == 3'b110)         kind = LEAD_TWO;
    else if (b[7:4] == 4'b1110)        kind = LEAD_THREE;
    else if (b[7:3] == 5'b11110)       kind = LEAD_FOUR;
    else                               kind = LEAD_BAD;
    return kind;
  endfunction

endpackage

// ----- rtl/utfd_decode.sv -----
`timescale 1ns / 1ps
// Sequence state and single-pass decode of one UTF-8 byte.
module utfd_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [utfd_pkg::ByteW-1:0]      byte_i,
  input  logic                            end_i,
  output utfd_pkg::emit_t                 emit_o,
  output logic                            idle_o
);
  import utfd_pkg::*;

  logic [1:0]     need_q, need_d;
  logic [1:0]     got_q, got_d;
  logic [CpW-1:0] part_q, part_d;

  logic              pending;
  logic              is_cont;
  logic [1:0]        got_inc;
  logic [CpW-1:0]    part_ext;
  logic [CountW-1:0] count;
  logic [CpW-1:0]    tail;
  lead_e             kind;

  assign pending  = (need_q != 2'd0);
  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign got_inc  = got_q + 2'd1;
  assign part_ext = {part_q[CpW-7:0], byte_i[5:0]};
  assign kind     = classify_lead(byte_i);

  always_comb begin
    need_d = need_q;
    got_d  = got_q;
    part_d = part_q;
    count  = '0;
    tail   = Replacement;

    if (pending && is_cont) begin
      if (got_inc == need_q) begin
        count  = CountW'(1);
        tail   = part_ext;
        need_d = 2'd0;
        got_d  = 2'd0;
        part_d = '0;
      end else begin
        got_d  = got_inc;
        part_d = part_ext;
      end
    end else begin
      // A broken sequence first flushes one replacement per buffered byte.
      if (pending) begin
        count = CountW'(got_q) + CountW'(1);
      end
      need_d = 2'd0;
      got_d  = 2'd0;
      part_d = '0;
      unique case (kind)
        LEAD_ASCII: begin
          count = count + CountW'(1);
          tail  = {{(CpW-ByteW){1'b0}}, byte_i};
        end
        LEAD_TWO: begin
          need_d = 2'd1;
          part_d = {{(CpW-5){1'b0}}, byte_i[4:0]};
        end
        LEAD_THREE: begin
          need_d = 2'd2;
          part_d = {{(CpW-4){1'b0}}, byte_i[3:0]};
        end
        LEAD_FOUR: begin
          need_d = 2'd3;
          part_d = {{(CpW-3){1'b0}}, byte_i[2:0]};
        end
        default: begin
          count = count + CountW'(1);
        end
      endcase
    end

    // A sequence still open at the end of the text is cut off.
    if (end_i && (need_d != 2'd0)) begin
      count  = count + CountW'(got_d) + CountW'(1);
      tail   = Replacement;
      need_d = 2'd0;
      got_d  = 2'd0;
      part_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 2'd0;
      got_q  <= 2'd0;
      part_q <= '0;
    end else if (accept_i) begin
      need_q <= need_d;
      got_q  <= got_d;
      part_q <= part_d;
    end
  end

  assign emit_o.count = count;
  assign emit_o.tail  = tail;
  assign emit_o.eot   = end_i;
  assign idle_o       = !pending;

endmodule

// ----- rtl/utf8_codepoint_decoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-8 codepoint decoder: stream ports and result register.
//
// Usage: the slave channel takes one UTF-8 byte per beat, with tlast marking
// the final byte of the text. The master channel gives one codepoint per beat;
// tlast marks the final codepoint caused by an input byte and tuser marks the
// final codepoint of the whole text. Invalid or cut-off input yields U+FFFD.
// A byte is decoded in the cycle it is accepted, against the sequence state,
// and its results land in the result register: the first result appears in
// the cycle after the input beat. So long as the receiver does not stall, a
// plain stream runs at one byte per cycle. A byte that causes n
// results (up to four, on a broken or cut-off sequence) holds the result
// register for n output beats, and the slave side waits until the last of
// them is taken. A byte that only opens or extends a sequence produces no
// output beat. When the receiver stalls, the result register holds its beat
// and new bytes are accepted only once that beat leaves. Reset clears the
// sequence state and empties the result register.
module utf8_codepoint_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] codepoint, [23:21] zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] end_of_text_out
);
  import utfd_pkg::*;

  logic              s_beat;
  logic              m_beat;
  logic              seq_idle;
  emit_t             emit;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CpW-1:0]    cp_q, cp_d;
  logic              eot_q, eot_d;
  logic              final_beat;

  assign final_beat      = (rem_q == CountW'(1));
  assign m_axis_tvalid_o = (rem_q != '0);
  assign s_axis_tready_o = (rem_q == '0) || (final_beat && m_axis_tready_i);
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_beat          = m_axis_tvalid_o && m_axis_tready_i;

  utfd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_beat),
    .byte_i   (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .emit_o   (emit),
    .idle_o   (seq_idle)
  );

  always_comb begin
    rem_d = rem_q;
    cp_d  = cp_q;
    eot_d = eot_q;
    if (m_beat) begin
      rem_d = rem_q - CountW'(1);
    end
    if (s_beat && (emit.count != '0)) begin
      rem_d = emit.count;
      cp_d  = emit.tail;
      eot_d = emit.eot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    eot_q <= eot_d;
  end

  // Every beat but the last of a byte is a replacement character.
  assign m_axis_tdata_o = {{(OutDataW-CpW){1'b0}}, (final_beat ? cp_q : Replacement)};
  assign m_axis_tlast_o = final_beat;
  assign m_axis_tuser_o = final_beat && eot_q;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= MaxResults)
    else $error("result count exceeds the maximum per byte");

  a_rem_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_beat && (rem_q > CountW'(1))) |=> (rem_q == $past(rem_q) - CountW'(1)))
    else $error("result count did not step down by one");

  a_fill_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[CpW-1:0] == Replacement))
    else $error("non-final beat is not a replacement");

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_beat && m_axis_tuser_o) |-> seq_idle)
    else $error("sequence still pending at end of text");
`endif

endmodule
